// ===== design/wtok_pkg.sv =====
// Package for the word tokenizer: payload structs, character codes and
// the saturating counter helper. No dependencies.
`timescale 1ns / 1ps

package wtok_pkg;

  // Character codes
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChNl    = 8'h0A;

  localparam logic [15:0] CntMax = 16'hFFFF;

  // Input transaction
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_marker;
  } wtok_in_t;

  // Result transaction
  typedef struct packed {
    logic        write_valid;
    logic [15:0] out_addr;
    logic [7:0]  out_byte;
    logic        start_valid;
    logic [15:0] start_word;
    logic [15:0] start_addr;
    logic        length_valid;
    logic [15:0] length_word;
    logic [15:0] length_value;
    logic        done_res;
    logic [15:0] char_total;
    logic [15:0] word_total;
  } wtok_out_t;

  // Tokenizer state carried from byte to byte
  typedef struct packed {
    logic        in_comment;
    logic        in_quote;
    logic        quote_is_double;
    logic        word_open;
    logic [15:0] current_length;
    logic [15:0] write_pointer;
    logic [15:0] quote_start;
    logic [15:0] stored_chars;
    logic [15:0] words_found;
  } wtok_state_t;

  // Saturating increment of a 16-bit counter
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == CntMax) ? v : v + 16'd1;
  endfunction

endpackage

// ===== design/wtok_core.sv =====
// Tokenizer state register and single-pass step logic for one byte.
// Depends on wtok_pkg.
`timescale 1ns / 1ps

module wtok_core #(
  parameter int unsigned BUFFER_DEPTH = 65536,
  parameter int unsigned MAX_WORDS    = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  wtok_pkg::wtok_in_t  item_i,
  output wtok_pkg::wtok_out_t res_o,
  output logic                has_res_o
);

  wtok_pkg::wtok_state_t st_q, st_d;
  wtok_pkg::wtok_out_t   res;
  logic [7:0]            c;
  logic [7:0]            qc;
  logic                  wr_ok;
  logic                  st_ok;
  logic                  len_ok;
  logic [15:0]           words_m1;

  assign c        = item_i.text_byte;
  assign qc       = st_q.quote_is_double ? wtok_pkg::ChDq : wtok_pkg::ChSq;
  assign words_m1 = st_q.words_found - 16'd1;
  assign wr_ok    = 32'(st_q.write_pointer) < BUFFER_DEPTH;
  assign st_ok    = 32'(st_q.words_found) < MAX_WORDS;
  assign len_ok   = (st_q.words_found != 16'd0) && (32'(words_m1) < MAX_WORDS);

  // Work out the next state and the result for the byte on hand
  always_comb begin
    st_d = st_q;
    res  = '0;
    if (item_i.end_marker) begin
      // Flush an open quote, report counts, clear for the next file
      if (st_q.in_quote) begin
        res.start_valid = st_ok;
        res.start_word  = st_ok ? st_q.words_found : 16'd0;
        res.start_addr  = st_ok ? st_q.quote_start : 16'd0;
        if (st_q.current_length != 16'd0) begin
          st_d.words_found = wtok_pkg::sat_inc(st_q.words_found);
        end
        res.write_valid = wr_ok;
        res.out_addr    = wr_ok ? st_q.write_pointer : 16'd0;
      end
      res.done_res   = 1'b1;
      res.char_total = st_q.stored_chars;
      res.word_total = st_d.words_found;
      st_d           = '0;
    end else if (!st_q.in_comment && c == wtok_pkg::ChHash) begin
      st_d.in_comment = 1'b1;
    end else if (!st_q.in_comment && !st_q.in_quote &&
                 (c == wtok_pkg::ChSq || c == wtok_pkg::ChDq)) begin
      // Open a quoted word
      st_d.in_quote        = 1'b1;
      st_d.quote_is_double = (c == wtok_pkg::ChDq);
      st_d.word_open       = 1'b1;
      st_d.current_length  = 16'd0;
      st_d.quote_start     = st_q.write_pointer;
    end else if (st_q.in_comment) begin
      if (c == wtok_pkg::ChNl) begin
        st_d.in_comment = 1'b0;
      end
    end else if (st_q.in_quote) begin
      if (c == qc) begin
        // Close the quote: start record and terminator, length kept
        st_d.in_quote   = 1'b0;
        st_d.word_open  = 1'b0;
        res.start_valid = st_ok;
        res.start_word  = st_ok ? st_q.words_found : 16'd0;
        res.start_addr  = st_ok ? st_q.quote_start : 16'd0;
        if (st_q.current_length != 16'd0) begin
          st_d.words_found = wtok_pkg::sat_inc(st_q.words_found);
        end
        res.write_valid    = wr_ok;
        res.out_addr       = wr_ok ? st_q.write_pointer : 16'd0;
        st_d.write_pointer = wtok_pkg::sat_inc(st_q.write_pointer);
      end else begin
        // Newline inside a quote counts but is not stored
        if (c != wtok_pkg::ChNl) begin
          res.write_valid    = wr_ok;
          res.out_addr       = wr_ok ? st_q.write_pointer : 16'd0;
          res.out_byte       = wr_ok ? c : 8'd0;
          st_d.write_pointer = wtok_pkg::sat_inc(st_q.write_pointer);
          st_d.stored_chars  = wtok_pkg::sat_inc(st_q.stored_chars);
        end
        st_d.current_length = wtok_pkg::sat_inc(st_q.current_length);
      end
    end else if (c != wtok_pkg::ChSp && c != wtok_pkg::ChTab &&
                 c != wtok_pkg::ChComma && c != wtok_pkg::ChNl) begin
      // Plain word character
      st_d.stored_chars   = wtok_pkg::sat_inc(st_q.stored_chars);
      st_d.current_length = wtok_pkg::sat_inc(st_q.current_length);
      if (!st_q.word_open) begin
        res.start_valid  = st_ok;
        res.start_word   = st_ok ? st_q.words_found : 16'd0;
        res.start_addr   = st_ok ? st_q.write_pointer : 16'd0;
        st_d.word_open   = 1'b1;
        st_d.words_found = wtok_pkg::sat_inc(st_q.words_found);
      end
      res.write_valid    = wr_ok;
      res.out_addr       = wr_ok ? st_q.write_pointer : 16'd0;
      res.out_byte       = wr_ok ? c : 8'd0;
      st_d.write_pointer = wtok_pkg::sat_inc(st_q.write_pointer);
    end else begin
      // Separator: close an open word with length record and terminator
      if (st_q.word_open && st_q.current_length != 16'd0) begin
        res.length_valid   = len_ok;
        res.length_word    = len_ok ? words_m1 : 16'd0;
        res.length_value   = len_ok ? st_q.current_length : 16'd0;
        res.write_valid    = wr_ok;
        res.out_addr       = wr_ok ? st_q.write_pointer : 16'd0;
        st_d.write_pointer = wtok_pkg::sat_inc(st_q.write_pointer);
      end
      st_d.word_open      = 1'b0;
      st_d.current_length = 16'd0;
    end
  end

  // Advance the state only when a byte is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign res_o     = res;
  assign has_res_o = res.write_valid | res.start_valid | res.length_valid | res.done_res;

endmodule

// ===== design/word_tokenizer_with_comments_quotes.sv =====
// Word tokenizer with comments and quotes: one byte per cycle in, result out.
// An accepted transaction is held in the input register, and its result is captured in the result register.
// Throughput: one byte per cycle; the input register refills while the
// result register drains, so stalls only follow out_ready_i.
// Reset: asynchronous active-low rst_ni clears all flags, counters and valids.
// Bytes that make no result are dropped after updating state.
`timescale 1ns / 1ps

module word_tokenizer_with_comments_quotes #(
  parameter int unsigned BUFFER_DEPTH = 65536,
  parameter int unsigned MAX_WORDS    = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wtok_pkg::wtok_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wtok_pkg::wtok_out_t out_data_o
);

  logic                in_vld_q;
  wtok_pkg::wtok_in_t  in_data_q;
  logic                out_vld_q;
  wtok_pkg::wtok_out_t out_data_q;
  logic                advance;
  logic                step;
  wtok_pkg::wtok_out_t res;
  logic                has_res;

  assign advance    = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  // Hold the incoming transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  wtok_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .MAX_WORDS   (MAX_WORDS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_data_q),
    .res_o    (res),
    .has_res_o(has_res)
  );

  // Register the result; drop bytes that make none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= step && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  // A word is never started and measured by the same byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.start_valid && out_data_o.length_valid))
    else $error("start and length record in one result");

  // An end-of-file result never carries a length record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> !out_data_o.length_valid)
    else $error("length record on end-of-file result");

  // Every delivered result carries at least one record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.write_valid || out_data_o.start_valid ||
                     out_data_o.length_valid || out_data_o.done_res))
    else $error("empty result delivered");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for word_tokenizer_with_comments_quotes: directed table
// and random text over four idling phases, checked against an in-bench tokenizer.
// Depends on wtok_pkg and the tokenizer RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned BufDepth   = 65536;
  localparam int unsigned MaxWords   = 65536;
  localparam int          WatchLimit = 2000;
  localparam int          PhaseItems = 330;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  wtok_pkg::wtok_in_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  wtok_pkg::wtok_out_t out_data_o;

  word_tokenizer_with_comments_quotes #(
    .BUFFER_DEPTH(BufDepth),
    .MAX_WORDS   (MaxWords)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // One row of the directed table
  typedef struct {
    wtok_pkg::wtok_in_t  stim;
    bit                  typed;
    wtok_pkg::wtok_out_t typed_res;
  } dir_row_t;

  // Tokenizer state mirrored by the predictor
  logic        cmt_active;
  logic        qt_active;
  logic        qt_double;
  logic        word_active;
  logic [15:0] run_len;
  logic [15:0] buf_ptr;
  logic [15:0] qt_base;
  logic [15:0] char_count;
  logic [15:0] word_count;

  wtok_pkg::wtok_out_t pending_res_q[$];
  dir_row_t            dir_tab[$];

  int send_idle_pct;
  int recv_stall_pct;
  int fault_count;
  int items_sent;
  int results_seen;
  int files_closed;
  int quiet_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [15:0] sat_up(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void clear_state();
    cmt_active  = 1'b0;
    qt_active   = 1'b0;
    qt_double   = 1'b0;
    word_active = 1'b0;
    run_len     = '0;
    buf_ptr     = '0;
    qt_base     = '0;
    char_count  = '0;
    word_count  = '0;
  endfunction

  // Store a byte at the buffer pointer; the pointer advances even past the end
  function automatic void put_byte(inout wtok_pkg::wtok_out_t r, input logic [7:0] b);
    if (int'(buf_ptr) < BufDepth) begin
      r.write_valid = 1'b1;
      r.out_addr    = buf_ptr;
      r.out_byte    = b;
    end
    buf_ptr = sat_up(buf_ptr);
  endfunction

  function automatic void put_start(inout wtok_pkg::wtok_out_t r, input logic [15:0] w,
                                    input logic [15:0] a);
    if (int'(w) < MaxWords) begin
      r.start_valid = 1'b1;
      r.start_word  = w;
      r.start_addr  = a;
    end
  endfunction

  // Close a quoted word: start record, count only if non-empty, terminator
  function automatic void close_quote(inout wtok_pkg::wtok_out_t r);
    put_start(r, word_count, qt_base);
    if (run_len != 0) word_count = sat_up(word_count);
    put_byte(r, 8'h00);
  endfunction

  // Advance the tokenizer by one transaction; returns 1 when a result is due
  function automatic bit tokenize_step(input wtok_pkg::wtok_in_t it,
                                       output wtok_pkg::wtok_out_t r);
    logic [7:0]  ch;
    logic [7:0]  close_ch;
    logic [15:0] addr;
    r  = '0;
    ch = it.text_byte;
    if (it.end_marker) begin
      if (qt_active) close_quote(r);
      r.done_res   = 1'b1;
      r.char_total = char_count;
      r.word_total = word_count;
      clear_state();
      return 1'b1;
    end
    if (!cmt_active && ch == wtok_pkg::ChHash) begin
      cmt_active = 1'b1;
      return 1'b0;
    end
    if (!cmt_active && !qt_active && (ch == wtok_pkg::ChSq || ch == wtok_pkg::ChDq)) begin
      qt_active   = 1'b1;
      qt_double   = (ch == wtok_pkg::ChDq);
      word_active = 1'b1;
      run_len     = '0;
      qt_base     = buf_ptr;
      return 1'b0;
    end
    if (cmt_active) begin
      if (ch == wtok_pkg::ChNl) cmt_active = 1'b0;
      return 1'b0;
    end
    if (qt_active) begin
      close_ch = qt_double ? wtok_pkg::ChDq : wtok_pkg::ChSq;
      if (ch == close_ch) begin
        qt_active   = 1'b0;
        word_active = 1'b0;
        close_quote(r);
      end else begin
        // newline inside a quote counts towards the length but is not stored
        if (ch != wtok_pkg::ChNl) begin
          put_byte(r, ch);
          char_count = sat_up(char_count);
        end
        run_len = sat_up(run_len);
      end
    end else if (ch != wtok_pkg::ChSp && ch != wtok_pkg::ChTab &&
                 ch != wtok_pkg::ChComma && ch != wtok_pkg::ChNl) begin
      addr       = buf_ptr;
      char_count = sat_up(char_count);
      run_len    = sat_up(run_len);
      if (!word_active) begin
        put_start(r, word_count, addr);
        word_active = 1'b1;
        word_count  = sat_up(word_count);
      end
      put_byte(r, ch);
    end else begin
      if (word_active && run_len != 0) begin
        if (word_count != 0 && int'(word_count) - 1 < MaxWords) begin
          r.length_valid = 1'b1;
          r.length_word  = word_count - 16'd1;
          r.length_value = run_len;
        end
        put_byte(r, 8'h00);
      end
      word_active = 1'b0;
      run_len     = '0;
    end
    return r.write_valid | r.start_valid | r.length_valid | r.done_res;
  endfunction

  function automatic wtok_pkg::wtok_out_t res_of(
      input logic wv, input logic [15:0] addr, input logic [7:0] byt,
      input logic sv, input logic [15:0] sw, input logic [15:0] sa,
      input logic lv, input logic [15:0] lw, input logic [15:0] lval,
      input logic dn, input logic [15:0] ct, input logic [15:0] wt);
    wtok_pkg::wtok_out_t r;
    r = '{wv, addr, byt, sv, sw, sa, lv, lw, lval, dn, ct, wt};
    return r;
  endfunction

  function automatic string fmt_res(input wtok_pkg::wtok_out_t r);
    return $sformatf({"wr=%0b@%h:%h st=%0b w%0d@%h len=%0b w%0d:%0d ",
                      "done=%0b chars=%0d words=%0d"},
                     r.write_valid, r.out_addr, r.out_byte, r.start_valid,
                     r.start_word, r.start_addr, r.length_valid, r.length_word,
                     r.length_value, r.done_res, r.char_total, r.word_total);
  endfunction

  // Present one transaction, hold it until accepted, then log its expectation
  task automatic drive_item(input wtok_pkg::wtok_in_t it, input bit typed,
                            input wtok_pkg::wtok_out_t typed_res);
    wtok_pkg::wtok_out_t pred;
    bit                  due;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    due = tokenize_step(it, pred);
    if (typed) begin
      if (typed_res != '0) pending_res_q.push_back(typed_res);
    end else if (due) begin
      pending_res_q.push_back(pred);
    end
    @(negedge clk_i);
  endtask

  task automatic feed_byte(input logic [7:0] b);
    wtok_pkg::wtok_in_t it;
    it.text_byte  = b;
    it.end_marker = 1'b0;
    drive_item(it, 1'b0, '0);
  endtask

  task automatic feed_end();
    wtok_pkg::wtok_in_t it;
    it.text_byte  = 8'($urandom_range(255));
    it.end_marker = 1'b1;
    drive_item(it, 1'b0, '0);
  endtask

  // Any byte that neither separates nor starts a quote or comment
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    if ($urandom_range(3) != 0) return 8'($urandom_range(8'h7A, 8'h61));
    do begin
      c = 8'($urandom_range(255));
    end while (c == wtok_pkg::ChSp || c == wtok_pkg::ChTab ||
               c == wtok_pkg::ChComma || c == wtok_pkg::ChNl ||
               c == wtok_pkg::ChHash || c == wtok_pkg::ChSq || c == wtok_pkg::ChDq);
    return c;
  endfunction

  function automatic logic [7:0] sep_char();
    case ($urandom_range(3))
      0:       return wtok_pkg::ChSp;
      1:       return wtok_pkg::ChTab;
      2:       return wtok_pkg::ChComma;
      default: return wtok_pkg::ChNl;
    endcase
  endfunction

  task automatic feed_word(input int n);
    repeat (n) feed_byte(word_char());
  endtask

  // One random stretch of text, mostly well-formed
  task automatic feed_chunk();
    int         kind;
    logic [7:0] q;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // plain word, occasionally left open so a quote or comment can follow
      feed_word($urandom_range(8, 1));
      if ($urandom_range(4) != 0) feed_byte(sep_char());
    end else if (kind < 55) begin
      // quoted word, sometimes with unquoted characters glued on
      q = $urandom_range(1) ? wtok_pkg::ChDq : wtok_pkg::ChSq;
      feed_byte(q);
      repeat ($urandom_range(6)) begin
        case ($urandom_range(5))
          0:       feed_byte(wtok_pkg::ChNl);
          1:       feed_byte((q == wtok_pkg::ChDq) ? wtok_pkg::ChSq : wtok_pkg::ChDq);
          2:       feed_byte(sep_char());
          default: feed_byte(word_char());
        endcase
      end
      feed_byte(q);
      if ($urandom_range(2) == 0) feed_word($urandom_range(3, 1));
      feed_byte(sep_char());
    end else if (kind < 65) begin
      // comment, possibly in the middle of a word
      if ($urandom_range(1)) feed_word($urandom_range(3, 1));
      feed_byte(wtok_pkg::ChHash);
      repeat ($urandom_range(5)) begin
        do c = 8'($urandom_range(255)); while (c == wtok_pkg::ChNl);
        feed_byte(c);
      end
      feed_byte(wtok_pkg::ChNl);
      if ($urandom_range(1)) feed_word($urandom_range(3, 1));
      feed_byte(sep_char());
    end else if (kind < 75) begin
      repeat ($urandom_range(3, 1)) feed_byte(sep_char());
    end else if (kind < 82) begin
      feed_end();
    end else if (kind < 90) begin
      // broken: quote or comment cut off by end of file
      feed_byte($urandom_range(2) == 0 ? wtok_pkg::ChHash :
                ($urandom_range(1) ? wtok_pkg::ChDq : wtok_pkg::ChSq));
      repeat ($urandom_range(4)) feed_byte(word_char());
      feed_end();
    end else begin
      repeat ($urandom_range(6, 1)) feed_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic e);
    dir_row_t row;
    row.stim.text_byte  = b;
    row.stim.end_marker = e;
    row.typed           = 1'b0;
    row.typed_res       = '0;
    dir_tab.push_back(row);
  endtask

  task automatic add_typed(input logic [7:0] b, input logic e,
                           input wtok_pkg::wtok_out_t r);
    add_row(b, e);
    dir_tab[$].typed     = 1'b1;
    dir_tab[$].typed_res = r;
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    wtok_pkg::wtok_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_data_o.done_res) files_closed++;
      if (pending_res_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("tb: unexpected result %s", fmt_res(out_data_o));
      end else begin
        want = pending_res_q.pop_front();
        if (out_data_o !== want) begin
          fault_count++;
          if (fault_count <= 10)
            $display("tb: mismatch on result %0d\n  expected %s\n  actual   %s",
                     results_seen, fmt_res(want), fmt_res(out_data_o));
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchLimit) begin
      $display("tb: timeout after %0d idle cycles", WatchLimit);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fault_count    = 0;
    items_sent     = 0;
    results_seen   = 0;
    files_closed   = 0;
    quiet_cycles   = 0;
    clear_state();

    // Directed table: extremes, separators, comments, quotes and end of file
    add_typed(8'hFF, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    add_typed("a", 1'b0, res_of(1, 0, "a", 1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_typed(8'hFF, 1'b0, res_of(1, 1, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_typed(wtok_pkg::ChSp, 1'b0, res_of(1, 2, 8'h00, 0, 0, 0, 1, 0, 2, 0, 0, 0));
    add_row(8'h00, 1'b0);
    add_row(wtok_pkg::ChTab, 1'b0);
    add_row(wtok_pkg::ChComma, 1'b0);
    add_row(wtok_pkg::ChHash, 1'b0);   // comment swallows the quote below
    add_row(wtok_pkg::ChDq, 1'b0);
    add_row(wtok_pkg::ChNl, 1'b0);
    add_row(wtok_pkg::ChSq, 1'b0);
    add_row(wtok_pkg::ChHash, 1'b0);   // comment opened inside a quote
    add_row("x", 1'b0);
    add_row(wtok_pkg::ChNl, 1'b0);
    add_row("q", 1'b0);
    add_row(wtok_pkg::ChNl, 1'b0);     // newline in a quote: length only
    add_row(wtok_pkg::ChDq, 1'b0);
    add_row(wtok_pkg::ChSq, 1'b0);
    add_row("b", 1'b0);                // length carries on from the quote
    add_row(wtok_pkg::ChDq, 1'b0);     // quote straight after an open word
    add_row(wtok_pkg::ChDq, 1'b0);     // empty quoted word
    add_row("w", 1'b0);
    add_row(wtok_pkg::ChHash, 1'b0);   // comment in the middle of a word
    add_row(wtok_pkg::ChNl, 1'b0);
    add_row(wtok_pkg::ChSq, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'h7F, 1'b1);              // end of file closes the open quote
    add_row("f", 1'b0);
    add_typed(8'h00, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1));

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) drive_item(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].typed_res);

    // Random text over the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int n = items_sent + PhaseItems; items_sent < n; ) feed_chunk();
    end
    feed_end();
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("tb: %0d bytes and end marks sent, %0d results checked, %0d files closed",
             items_sent, results_seen, files_closed);
    $display("tb: %0d faults (directed table and four idling phases of random text)",
             fault_count);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/wtok_pkg.sv
design/wtok_core.sv
design/word_tokenizer_with_comments_quotes.sv
tb/tb.sv
